[rtl/fmrp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fmrp_pkg: shared types and constants for the framed message receive pool
// Request codes, slot status codes, payload structs and controller commands.
// ----------------------------------------------------------------------------
package fmrp_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_FETCH = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_FILLING = 2'd1,
    ST_VALID   = 2'd2
  } slot_st_e;

  localparam logic [0:0] REG_START = 1'b0;
  localparam logic [0:0] REG_END   = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic       line_error;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] data_byte;
    logic [5:0] msg_length;
    logic [7:0] msg_tag;
    logic       last;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic do_byte;    // apply received byte to the pool
    logic do_flush;   // clear the pool
    logic do_search;  // latch fetch search result
    logic rd_issue;   // issue memory read at current fetch index
    logic emit;       // load output register from read data
    logic miss;       // load output register with not-found result
    logic free_hit;   // free matched slot, advance read sequence
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    req_e req;
    logic err;
    logic hit;
    logic rd_last;  // the read now in flight is the final byte
  } sts_t;

endpackage
`default_nettype wire

[rtl/fmrp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fmrp_if: valid/ready channel carrying one payload
// Generic stream interface with source and sink modports.
// ----------------------------------------------------------------------------
interface fmrp_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/fmrp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fmrp_ram: generic single-port-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fmrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/fmrp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fmrp_ctrl: request sequencer
// Accepts one item, dispatches it to the datapath and paces fetch streaming.
// ----------------------------------------------------------------------------
module fmrp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  input  wire fmrp_pkg::sts_t sts_i,
  output fmrp_pkg::cmd_t      cmd_o
);
  import fmrp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DISP   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_READ   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_WAIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   last_q, last_d;

  assign out_valid_o = out_valid_q;
  // Output register frees as it is taken, so input acceptance overlaps drain.
  assign in_ready_o  = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    last_d      = last_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.req)
          REQ_BYTE: begin
            cmd_o.do_byte = !sts_i.err;
            state_d       = S_IDLE;
          end
          REQ_FETCH: begin
            cmd_o.do_search = 1'b1;
            state_d         = S_SEARCH;
          end
          REQ_FLUSH: begin
            cmd_o.do_flush = 1'b1;
            state_d        = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        if (!sts_i.hit) begin
          if (!out_valid_d) begin
            cmd_o.miss  = 1'b1;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          cmd_o.rd_issue = 1'b1;
          last_d         = sts_i.rd_last;
          state_d        = S_EMIT;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        last_d         = sts_i.rd_last;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        // Read data is registered; hold it until the output register frees.
        if (!out_valid_d) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (last_q) begin
            cmd_o.free_hit = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_valid_d) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (last_q) begin
            cmd_o.free_hit = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end
endmodule
`default_nettype wire

[rtl/fmrp_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fmrp_dp: pool datapath
// Slot table, byte memory, sequence counters, search and output register.
// ----------------------------------------------------------------------------
module fmrp_dp #(
  parameter int unsigned NUM_SLOTS = 4,
  parameter int unsigned MSG_BYTES = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fmrp_pkg::in_t  in_i,
  input  wire logic [7:0]     start_code_i,
  input  wire logic [7:0]     end_code_i,
  input  wire fmrp_pkg::cmd_t cmd_i,
  output fmrp_pkg::sts_t      sts_o,
  output fmrp_pkg::out_t      out_o
);
  import fmrp_pkg::*;

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned LW = $clog2(MSG_BYTES + 1);
  localparam int unsigned DEPTH = NUM_SLOTS * MSG_BYTES;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_t             item_q;
  slot_st_e        st_q   [NUM_SLOTS];
  logic [7:0]      tag_q  [NUM_SLOTS];
  logic [LW-1:0]   len_q  [NUM_SLOTS];
  logic [SW-1:0]   act_q;
  logic            held_q;
  logic [7:0]      rx_seq_q, rd_seq_q;
  logic            hit_q;
  logic [SW-1:0]   hit_slot_q;
  logic [LW-1:0]   idx_q;
  out_t            out_q;

  logic            held_fill, hit_c, empty_c;
  logic [SW-1:0]   hit_slot_c, empty_slot_c;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      rdata;

  assign held_fill = held_q && (st_q[act_q] == ST_FILLING);

  // Priority search, lowest slot wins.
  always_comb begin
    hit_c        = 1'b0;
    hit_slot_c   = '0;
    empty_c      = 1'b0;
    empty_slot_c = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (st_q[s] == ST_VALID && tag_q[s] == rd_seq_q) begin
        hit_c      = 1'b1;
        hit_slot_c = SW'(s);
      end
      if (st_q[s] == ST_EMPTY) begin
        empty_c      = 1'b1;
        empty_slot_c = SW'(s);
      end
    end
  end

  logic is_start, is_end;
  assign is_start = item_q.rx_byte == start_code_i;
  assign is_end   = item_q.rx_byte == end_code_i;

  assign we    = cmd_i.do_byte && !is_start && !is_end && held_fill &&
                 (len_q[act_q] < LW'(MSG_BYTES));
  assign waddr = AW'(act_q * MSG_BYTES) + AW'(len_q[act_q]);
  // Between reads, hold the last issued address so stalled read data stays put.
  assign raddr = AW'(hit_slot_q * MSG_BYTES) +
                 AW'(cmd_i.rd_issue ? idx_q : idx_q - LW'(1));

  fmrp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_q.rx_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.req     = req_e'(item_q.req_type);
  assign sts_o.err     = item_q.line_error;
  assign sts_o.hit     = hit_q;
  assign sts_o.rd_last = (idx_q + LW'(1)) == len_q[hit_slot_q];
  assign out_o         = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.emit) begin
      out_q.found      <= 1'b1;
      out_q.data_byte  <= rdata;
      out_q.msg_length <= 6'(len_q[hit_slot_q]);
      out_q.msg_tag    <= tag_q[hit_slot_q];
      out_q.last       <= (idx_q == len_q[hit_slot_q]);
    end else if (cmd_i.miss) begin
      out_q <= '{found: 1'b0, data_byte: 8'd0, msg_length: 6'd0, msg_tag: 8'd0,
                 last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        st_q[s]  <= ST_EMPTY;
        tag_q[s] <= '0;
        len_q[s] <= '0;
      end
      act_q      <= '0;
      held_q     <= 1'b1;
      rx_seq_q   <= '0;
      rd_seq_q   <= '0;
      hit_q      <= 1'b0;
      hit_slot_q <= '0;
      idx_q      <= '0;
    end else begin
      if (cmd_i.do_flush) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          st_q[s]  <= ST_EMPTY;
          tag_q[s] <= '0;
          len_q[s] <= '0;
        end
        act_q    <= '0;
        held_q   <= 1'b1;
        rx_seq_q <= '0;
        rd_seq_q <= '0;
      end
      if (cmd_i.do_byte) begin
        if (is_start) begin
          if (held_fill) begin
            len_q[act_q] <= '0;
          end else if (empty_c) begin
            act_q               <= empty_slot_c;
            held_q              <= 1'b1;
            st_q[empty_slot_c]  <= ST_FILLING;
            tag_q[empty_slot_c] <= rx_seq_q;
            rx_seq_q            <= rx_seq_q + 8'd1;
          end else begin
            held_q <= 1'b0;
          end
        end else if (held_fill) begin
          if (is_end) begin
            if (len_q[act_q] != '0) st_q[act_q] <= ST_VALID;
          end else if (we) begin
            len_q[act_q] <= len_q[act_q] + LW'(1);
          end
        end
      end
      if (cmd_i.do_search) begin
        hit_q      <= hit_c;
        hit_slot_q <= hit_slot_c;
        idx_q      <= '0;
      end
      if (cmd_i.rd_issue) idx_q <= idx_q + LW'(1);
      if (cmd_i.free_hit) begin
        st_q[hit_slot_q]  <= ST_EMPTY;
        tag_q[hit_slot_q] <= '0;
        len_q[hit_slot_q] <= '0;
        rd_seq_q          <= rd_seq_q + 8'd1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/framed_message_receive_pool_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// framed_message_receive_pool_core: framed message receive pool
// Collects start/end framed serial bytes into message slots and streams out
// completed messages in sequence order on request.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  (sink)  : one request per transaction: received byte, fetch, or
//                    flush. Bytes with line_error set are dropped.
//   out_if (source): fetch results, one transaction per payload byte with
//                    last on the final one, or a single not-found transaction.
//   APB port       : start_code at 0x0, end_code at 0x4; write only when idle.
// Sequencing:
//   A byte or flush request is captured, then applied; the next request is
//   taken once the block is idle again. A fetch searches the slot table,
//   then each byte takes one memory read and then one output load, an order
//   set by the single registered read port of the byte memory.
// Reset: all slots empty, slot 0 held, both sequence numbers zero, codes 2/3.
// Stall: when the receiver holds ready low the output register keeps its
//   transaction and the fetch sequencer waits; no result is lost.
// ----------------------------------------------------------------------------
module framed_message_receive_pool_core #(
  parameter int unsigned NUM_SLOTS = 4,
  parameter int unsigned MSG_BYTES = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  fmrp_if.sink            in_if,
  fmrp_if.source          out_if,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:2] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import fmrp_pkg::*;

  logic [7:0] start_code_q, end_code_q;
  cmd_t       cmd;
  sts_t       sts;
  out_t       out_data;
  in_t        in_data;

  // Config registers; every write lands in the access phase.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= 8'd2;
      end_code_q   <= 8'd3;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_START: start_code_q <= pwdata[7:0];
        REG_END:   end_code_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  assign prdata = {24'd0, (paddr[2] == REG_END) ? end_code_q : start_code_q};

  assign in_data = in_t'(in_if.payload);

  fmrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmrp_dp #(.NUM_SLOTS(NUM_SLOTS), .MSG_BYTES(MSG_BYTES)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_data),
    .start_code_i (start_code_q),
    .end_code_i   (end_code_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_o        (out_data)
  );

  assign out_if.payload = out_data;

  // Emit and miss never load the output register together.
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.emit && cmd.miss)) else $error("emit and miss together");

  // No new request is taken while a fetch stream is pending.
  a_no_accept_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_issue |-> !in_if.ready) else $error("accept during fetch");

  // A not-found result is always the last of its request.
  a_miss_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.miss |=> (out_if.valid && out_data.last && !out_data.found))
    else $error("not-found result malformed");
endmodule
`default_nettype wire

[verif/framed_message_receive_pool_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_message_receive_pool_core_tb: self-checking bench for the receive pool
// Drives framed byte sequences, fetches and flushes through the request
// channel, predicts every fetch result with a behavioral pool model and
// compares each output transaction field by field. Start and end codes are
// rewritten over APB between phases, with random idling on both channels.
// ----------------------------------------------------------------------------
module framed_message_receive_pool_core_tb;
  import fmrp_pkg::*;

  localparam int unsigned SLOTS = 4;
  localparam int unsigned DEPTH = 32;

  localparam out_t NOT_FOUND = '{found: 1'b0, data_byte: 8'd0, msg_length: 6'd0,
                                 msg_tag: 8'd0, last: 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fmrp_if #(.W($bits(in_t)))  req_ch ();
  fmrp_if #(.W($bits(out_t))) res_ch ();

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:2]  paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  framed_message_receive_pool_core #(.NUM_SLOTS(SLOTS), .MSG_BYTES(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_ch.sink),
    .out_if (res_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    res_ch.ready = 1'b0;
  end

  // Pool model state
  logic [7:0] start_code_q, end_code_q;
  slot_st_e   pool_status [SLOTS];
  logic [7:0] pool_tag    [SLOTS];
  logic [5:0] pool_len    [SLOTS];
  logic [7:0] pool_data   [SLOTS][DEPTH];
  int unsigned held_slot;
  bit          holding;
  logic [7:0]  rx_seq, rd_seq;

  out_t        pending_results[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic void clear_pool();
    rx_seq = '0;
    rd_seq = '0;
    held_slot = 0;
    holding = 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      pool_status[s] = ST_EMPTY;
      pool_tag[s] = '0;
      pool_len[s] = '0;
    end
  endfunction

  function automatic bit held_filling();
    return holding && pool_status[held_slot] == ST_FILLING;
  endfunction

  // Advance the pool model by one accepted request and queue its results.
  function automatic void predict_pool(in_t it);
    out_t r;
    int   hit;
    hit = -1;
    case (req_e'(it.req_type))
      REQ_BYTE: begin
        if (!it.line_error) begin
          if (it.rx_byte == start_code_q) begin
            if (held_filling()) begin
              pool_len[held_slot] = '0;
            end else begin
              holding = 1'b0;
              for (int s = 0; s < SLOTS; s++) begin
                if (!holding && pool_status[s] == ST_EMPTY) begin
                  held_slot = s;
                  holding = 1'b1;
                  pool_status[s] = ST_FILLING;
                  pool_tag[s] = rx_seq;
                  rx_seq++;
                end
              end
            end
          end else if (held_filling()) begin
            if (it.rx_byte == end_code_q) begin
              if (pool_len[held_slot] != 0) pool_status[held_slot] = ST_VALID;
            end else if (pool_len[held_slot] < DEPTH) begin
              pool_data[held_slot][pool_len[held_slot][4:0]] = it.rx_byte;
              pool_len[held_slot]++;
            end
          end
        end
      end
      REQ_FETCH: begin
        for (int s = SLOTS - 1; s >= 0; s--)
          if (pool_status[s] == ST_VALID && pool_tag[s] == rd_seq) hit = s;
        if (hit < 0) begin
          r = '0;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          rd_seq++;
          for (int k = 0; k < pool_len[hit]; k++) begin
            r.found = 1'b1;
            r.data_byte = pool_data[hit][k];
            r.msg_length = pool_len[hit];
            r.msg_tag = pool_tag[hit];
            r.last = (k + 1 == pool_len[hit]);
            pending_results.push_back(r);
          end
          pool_status[hit] = ST_EMPTY;
          pool_tag[hit] = '0;
          pool_len[hit] = '0;
        end
      end
      REQ_FLUSH: clear_pool();
      default: ;
    endcase
  endfunction

  // Receiver: random stall, compare each accepted result with the oldest one due.
  always @(posedge clk_i) begin
    out_t got, want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got = out_t'(res_ch.payload);
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %p", got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0h actual %0h", want.found, got.found);
            fail_count++;
          end
          if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h actual %0h", want.data_byte, got.data_byte);
            fail_count++;
          end
          if (got.msg_length !== want.msg_length) begin
            $error("msg_length: expected %0d actual %0d", want.msg_length, got.msg_length);
            fail_count++;
          end
          if (got.msg_tag !== want.msg_tag) begin
            $error("msg_tag: expected %0h actual %0h", want.msg_tag, got.msg_tag);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0h actual %0h", want.last, got.last);
            fail_count++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one request: optional idle gaps, then hold valid until accepted.
  // Valid stays up after acceptance; an idle gap or a drain drops it, else the next request takes it over.
  task automatic send_request(input req_e kind, input logic [7:0] b, input logic err);
    in_t it;
    it.req_type = kind;
    it.rx_byte = b;
    it.line_error = err;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= it;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_pool(it);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write one code register over APB; the block must be idle.
  task automatic write_code(input logic [0:0] idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_START) start_code_q = value;
    else end_code_q = value;
  endtask

  // Frame with random content; sometimes broken (no end code, error bytes).
  task automatic send_frame(input int len, input bit close);
    logic [7:0] b;
    send_request(REQ_BYTE, start_code_q, 1'b0);
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom_range(255));
      send_request(REQ_BYTE, b, ($urandom_range(15) == 0));
    end
    if (close) send_request(REQ_BYTE, end_code_q, 1'b0);
  endtask

  typedef struct {
    req_e       kind;
    logic [7:0] b;
    logic       err;
    bit         chk;
    out_t       exp;
  } stim_row_t;

  // Directed table: frames at reset codes, extremes, empty frame, misses,
  // error bytes, unused request, flush.
  stim_row_t directed_rows[] = '{
    '{REQ_FETCH, 8'h00, 1'b0, 1'b1, NOT_FOUND},  // nothing pending: not-found
    '{REQ_BYTE,  8'h03, 1'b0, 1'b0, NOT_FOUND},  // end code on empty held slot
    '{REQ_BYTE,  8'h55, 1'b0, 1'b0, NOT_FOUND},  // data, held slot not filling
    '{REQ_BYTE,  8'h02, 1'b0, 1'b0, NOT_FOUND},  // claim slot 0, tag 0
    '{REQ_BYTE,  8'h03, 1'b0, 1'b0, NOT_FOUND},  // end on empty frame
    '{REQ_BYTE,  8'h00, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_BYTE,  8'hFF, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_BYTE,  8'hAA, 1'b1, 1'b0, NOT_FOUND},  // line error: dropped
    '{REQ_BYTE,  8'h03, 1'b0, 1'b0, NOT_FOUND},  // close, two bytes
    '{REQ_NONE,  8'hFF, 1'b1, 1'b0, NOT_FOUND},  // unused request: ignored
    '{REQ_FETCH, 8'h00, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_FETCH, 8'h00, 1'b0, 1'b1, NOT_FOUND},  // miss
    '{REQ_BYTE,  8'h02, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_BYTE,  8'h11, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_BYTE,  8'h02, 1'b0, 1'b0, NOT_FOUND},  // restart filling slot
    '{REQ_BYTE,  8'h22, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_BYTE,  8'h03, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_FLUSH, 8'h00, 1'b0, 1'b0, NOT_FOUND},
    '{REQ_FETCH, 8'h00, 1'b0, 1'b1, NOT_FOUND}   // after flush: miss
  };

  initial begin
    in_t it;
    start_code_q = 8'h02;
    end_code_q = 8'h03;
    clear_pool();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].b, directed_rows[i].err);
      // Rows with a typed result check the block against it directly.
      if (directed_rows[i].chk) begin
        void'(pending_results.pop_back());
        pending_results.push_back(directed_rows[i].exp);
      end
    end
    // Overflow: 40 data bytes into a 32 byte slot, then fill every slot.
    send_frame(40, 1'b1);
    drain_results();
    for (int s = 0; s < SLOTS + 1; s++) send_frame(1, 1'b1);
    for (int s = 0; s < SLOTS + 1; s++) send_request(REQ_FETCH, 8'h00, 1'b0);
    drain_results();

    // Phases: idling mixes and code settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (ph)
        0: begin write_code(REG_START, 8'h00); write_code(REG_END, 8'hFF); end
        1: begin write_code(REG_START, 8'hFF); write_code(REG_END, 8'h00); end
        2: begin write_code(REG_START, 8'h7E); write_code(REG_END, 8'h7E); end
        3: begin write_code(REG_START, 8'($urandom_range(255)));
                 write_code(REG_END, 8'($urandom_range(255))); end
        default: begin write_code(REG_START, 8'h02); write_code(REG_END, 8'h03); end
      endcase
      for (int n = 0; n < 2; n++) begin
        case ($urandom_range(9))
          0: send_request(req_e'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
          1: send_frame($urandom_range(3), 1'b0);
          default: send_frame($urandom_range(1, 5), 1'b1);
        endcase
        if ($urandom_range(2) == 0)
          send_request(REQ_FETCH, 8'($urandom_range(255)), 1'b0);
      end
      // Pause the sender until everything due has come out.
      drain_results();
      repeat (3) send_request(REQ_FETCH, 8'h00, 1'b0);
      drain_results();
    end

    drain_results();
    if (fail_count == 0) begin
      $display("framed_message_receive_pool_core verification clean");
    end else begin
      $display("framed_message_receive_pool_core verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("framed_message_receive_pool_core verification failed");
    $finish;
  end

endmodule
